// ----- sv/phd_pkg.sv -----
// Shared constants, codes and stage records for the heater duty PID controller.
`default_nettype none
package phd_pkg;

  // Field widths
  localparam int TEMP_W    = 16;
  localparam int TGT_W     = 10;
  localparam int TGT10_W   = 14;
  localparam int GAIN_W    = 32;
  localparam int CAP_W     = 31;
  localparam int ERR_W     = 17;
  localparam int DERR_W    = 18;
  localparam int PT_W      = GAIN_W + 1 + ERR_W;   // signed proportional term
  localparam int IT_W      = GAIN_W + CAP_W;       // unsigned integral term
  localparam int DT_W      = GAIN_W + 1 + DERR_W;  // signed derivative term
  localparam int TOT_W     = 66;                   // signed weighted sum
  localparam int FRAC_BITS = 24;
  localparam int Q_W       = TOT_W - FRAC_BITS;
  localparam int DUTY_W    = 10;
  localparam int DMAX_W    = 16;
  localparam int IDX_W     = 3;
  localparam int KIND_W    = 2;

  // Output ceiling
  localparam logic [DMAX_W-1:0] DUTY_MAX = 16'd512;

  // Regulation window, tenths of a degree, both ends exclusive
  localparam logic signed [TEMP_W-1:0] WIN_LO = 16'sd200;
  localparam logic signed [TEMP_W-1:0] WIN_HI = 16'sd3000;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_TARGET = 3'd0;
  localparam logic [IDX_W-1:0] REG_KP     = 3'd1;
  localparam logic [IDX_W-1:0] REG_KI     = 3'd2;
  localparam logic [IDX_W-1:0] REG_KD     = 3'd3;
  localparam logic [IDX_W-1:0] REG_CAP    = 3'd4;

  // Register reset values
  localparam logic [TGT_W-1:0]  RST_TARGET = 10'd50;
  localparam logic [GAIN_W-1:0] RST_KP     = 32'd58720256;
  localparam logic [GAIN_W-1:0] RST_KI     = 32'd50332;
  localparam logic [GAIN_W-1:0] RST_KD     = 32'd0;
  localparam logic [CAP_W-1:0]  RST_CAP    = 31'd166667;

  // What a request does to the output
  localparam logic [KIND_W-1:0] KIND_PAUSE = 2'd0;  // duty 0, issued
  localparam logic [KIND_W-1:0] KIND_SKIP  = 2'd1;  // outside window, not issued
  localparam logic [KIND_W-1:0] KIND_REG   = 2'd2;  // regulated duty

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ERR_W-1:0]  err;    // two's complement
    logic [DERR_W-1:0] derr;   // two's complement
    logic [CAP_W-1:0]  esum;   // updated error sum
  } err_stage_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PT_W-1:0]   pterm;  // two's complement
    logic [IT_W-1:0]   iterm;
    logic [DT_W-1:0]   dterm;  // two's complement
  } mul_stage_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              big;    // integral term alone above 2^62
    logic [TOT_W-1:0]  total;  // two's complement
  } sum_stage_t;

endpackage
`default_nettype wire

// ----- sv/phd_err.sv -----
// Error, error sum and derivative stage; holds the controller state.
`default_nettype none
module phd_err import phd_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     valid_i,
  output logic                          ready_o,
  input  wire logic signed [TEMP_W-1:0] temp_i,
  input  wire logic                     run_i,
  input  wire logic [TGT_W-1:0]         target_i,
  input  wire logic [CAP_W-1:0]         cap_i,
  output logic                          valid_o,
  input  wire logic                     ready_i,
  output err_stage_t                    stage_o
);

  logic                     valid_r;
  err_stage_t               stage_r;
  logic [CAP_W-1:0]         error_sum_r;
  logic [ERR_W-1:0]         last_error_r;

  logic                     load;
  logic [TGT10_W-1:0]       tgt10;
  logic signed [ERR_W-1:0]  err;
  logic signed [CAP_W+1:0]  acc;
  logic [CAP_W-1:0]         sum_nxt;
  logic signed [DERR_W-1:0] derr;
  logic                     in_win;
  logic [KIND_W-1:0]        kind;

  assign ready_o = !valid_r || ready_i;
  assign load    = valid_i && ready_o;

  // Error in tenths and window check
  always_comb begin
    tgt10  = TGT10_W'(target_i) * 14'd10;
    err    = $signed({{(ERR_W-TGT10_W){1'b0}}, tgt10})
           - $signed({{(ERR_W-TEMP_W){temp_i[TEMP_W-1]}}, temp_i});
    in_win = (temp_i > WIN_LO) && (temp_i < WIN_HI);
    if (!run_i) begin
      kind = KIND_PAUSE;
    end else if (!in_win) begin
      kind = KIND_SKIP;
    end else begin
      kind = KIND_REG;
    end
  end

  // Clamped error sum and derivative
  always_comb begin
    acc  = $signed({2'b00, error_sum_r})
         + $signed({{(CAP_W+2-ERR_W){err[ERR_W-1]}}, err});
    if (acc[CAP_W+1]) begin
      sum_nxt = '0;
    end else if (acc[CAP_W:0] > {1'b0, cap_i}) begin
      sum_nxt = cap_i;
    end else begin
      sum_nxt = acc[CAP_W-1:0];
    end
    derr = $signed({err[ERR_W-1], err})
         - $signed({last_error_r[ERR_W-1], last_error_r});
  end

  // State and stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      error_sum_r  <= '0;
      last_error_r <= '0;
    end else begin
      if (ready_o) begin
        valid_r <= valid_i;
      end
      if (load) begin
        case (kind)
          KIND_PAUSE: error_sum_r <= '0;
          KIND_REG: begin
            error_sum_r  <= sum_nxt;
            last_error_r <= err;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_r.kind <= kind;
      stage_r.err  <= err;
      stage_r.derr <= derr;
      stage_r.esum <= sum_nxt;
    end
  end

  assign valid_o = valid_r;
  assign stage_o = stage_r;

endmodule
`default_nettype wire

// ----- sv/phd_mul.sv -----
// Gain multiply stage: one product per term, registered.
`default_nettype none
module phd_mul import phd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire err_stage_t        stage_i,
  input  wire logic [GAIN_W-1:0] kp_i,
  input  wire logic [GAIN_W-1:0] ki_i,
  input  wire logic [GAIN_W-1:0] kd_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output mul_stage_t             stage_o
);

  logic                   valid_r;
  mul_stage_t             stage_r;
  logic                   load;
  logic signed [PT_W-1:0] pterm;
  logic [IT_W-1:0]        iterm;
  logic signed [DT_W-1:0] dterm;

  assign ready_o = !valid_r || ready_i;
  assign load    = valid_i && ready_o;

  // Unsigned gains against the signed error and derivative and the unsigned sum
  always_comb begin
    pterm = $signed({1'b0, kp_i}) * $signed(stage_i.err);
    iterm = IT_W'(ki_i) * IT_W'(stage_i.esum);
    dterm = $signed({1'b0, kd_i}) * $signed(stage_i.derr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_r.kind  <= stage_i.kind;
      stage_r.pterm <= pterm;
      stage_r.iterm <= iterm;
      stage_r.dterm <= dterm;
    end
  end

  assign valid_o = valid_r;
  assign stage_o = stage_r;

endmodule
`default_nettype wire

// ----- sv/phd_sum.sv -----
// Weighted sum stage: adds the three terms and flags a huge integral term.
`default_nettype none
module phd_sum import phd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire mul_stage_t stage_i,
  output logic            valid_o,
  input  wire logic       ready_i,
  output sum_stage_t      stage_o
);

  logic             valid_r;
  sum_stage_t       stage_r;
  logic             load;
  logic             big;
  logic [TOT_W-1:0] total;

  assign ready_o = !valid_r || ready_i;
  assign load    = valid_i && ready_o;

  // Sign-extend and add; integral term above 2^62 saturates later
  always_comb begin
    big   = stage_i.iterm[IT_W-1] && (|stage_i.iterm[IT_W-2:0]);
    total = {{(TOT_W-PT_W){stage_i.pterm[PT_W-1]}}, stage_i.pterm}
          + {{(TOT_W-IT_W){1'b0}}, stage_i.iterm}
          + {{(TOT_W-DT_W){stage_i.dterm[DT_W-1]}}, stage_i.dterm};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_r.kind  <= stage_i.kind;
      stage_r.big   <= big;
      stage_r.total <= total;
    end
  end

  assign valid_o = valid_r;
  assign stage_o = stage_r;

endmodule
`default_nettype wire

// ----- sv/phd_sat.sv -----
// Output stage: scales, clamps to the duty range and holds the result.
`default_nettype none
module phd_sat import phd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire sum_stage_t stage_i,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [DUTY_W-1:0] out_duty,
  output logic            out_duty_written
);

  logic              valid_r;
  logic [DUTY_W-1:0] duty_r;
  logic              written_r;
  logic              load;
  logic [Q_W-1:0]    q;
  logic [DMAX_W-1:0] sat;
  logic [DMAX_W-1:0] duty_full;
  logic              written;

  assign ready_o = !valid_r || out_ready;
  assign load    = valid_i && ready_o;

  // Drop fraction bits and clamp to 0..DUTY_MAX
  always_comb begin
    q = stage_i.total[TOT_W-1:FRAC_BITS];
    if (stage_i.big) begin
      sat = DUTY_MAX;
    end else if (stage_i.total[TOT_W-1]) begin
      sat = '0;
    end else if (q > {{(Q_W-DMAX_W){1'b0}}, DUTY_MAX}) begin
      sat = DUTY_MAX;
    end else begin
      sat = q[DMAX_W-1:0];
    end
    case (stage_i.kind)
      KIND_REG: begin
        duty_full = sat;
        written   = 1'b1;
      end
      KIND_PAUSE: begin
        duty_full = '0;
        written   = 1'b1;
      end
      default: begin
        duty_full = '0;
        written   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      duty_r    <= duty_full[DUTY_W-1:0];
      written_r <= written;
    end
  end

  assign out_valid        = valid_r;
  assign out_duty         = duty_r;
  assign out_duty_written = written_r;

endmodule
`default_nettype wire

// ----- sv/pid_heater_duty_control.sv -----
// Top level of the heater duty PID controller: registers, input stage, pipeline.
//
// One temperature request per control tick goes through five register stages
// (input, error and state update, gain multiply, weighted sum, clamp/output),
// and while out_ready does not stall the output a new request can be taken
// every cycle; the throughput of one request per cycle is set by the
// error-sum update, which finishes in the single error stage before the next
// request reaches it. Each stage has its own valid bit and moves whenever the
// stage after it is empty or moving, so a stalled output only backs up the
// pipeline once all stages are full. A paused request gives duty 0 and clears
// the error sum; a running request with a temperature not strictly between
// 20.0 and 300.0 degrees gives a result with duty_written low and leaves the
// state alone. Registers are written through cfg_we/cfg_idx/cfg_wdata and
// should only change while no request is in flight.
`default_nettype none
module pid_heater_duty_control import phd_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [IDX_W-1:0]         cfg_idx,
  input  wire logic [GAIN_W-1:0]        cfg_wdata,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [TEMP_W-1:0] in_temp_tenths,
  input  wire logic                     in_running,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [DUTY_W-1:0]             out_duty,
  output logic                          out_duty_written
);

  localparam logic [2:0] PIPE_DEPTH = 3'd5;

  logic [TGT_W-1:0]         target_r;
  logic [GAIN_W-1:0]        kp_r;
  logic [GAIN_W-1:0]        ki_r;
  logic [GAIN_W-1:0]        kd_r;
  logic [CAP_W-1:0]         cap_r;

  logic                     s0_valid_r;
  logic signed [TEMP_W-1:0] s0_temp_r;
  logic                     s0_run_r;

  logic                     s1_ready;
  logic                     s1_valid;
  err_stage_t               s1_stage;
  logic                     s2_ready;
  logic                     s2_valid;
  mul_stage_t               s2_stage;
  logic                     s3_ready;
  logic                     s3_valid;
  sum_stage_t               s3_stage;
  logic                     s4_ready;

  logic [2:0]               occ_r;
  logic [2:0]               occ_nxt;
  logic                     in_acc;
  logic                     out_acc;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= RST_TARGET;
      kp_r     <= RST_KP;
      ki_r     <= RST_KI;
      kd_r     <= RST_KD;
      cap_r    <= RST_CAP;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TARGET: target_r <= cfg_wdata[TGT_W-1:0];
        REG_KP:     kp_r     <= cfg_wdata;
        REG_KI:     ki_r     <= cfg_wdata;
        REG_KD:     kd_r     <= cfg_wdata;
        REG_CAP:    cap_r    <= cfg_wdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  assign in_ready = !s0_valid_r || s1_ready;
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_temp_r <= in_temp_tenths;
      s0_run_r  <= in_running;
    end
  end

  phd_err u_err (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (s0_valid_r),
    .ready_o  (s1_ready),
    .temp_i   (s0_temp_r),
    .run_i    (s0_run_r),
    .target_i (target_r),
    .cap_i    (cap_r),
    .valid_o  (s1_valid),
    .ready_i  (s2_ready),
    .stage_o  (s1_stage)
  );

  phd_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s1_valid),
    .ready_o (s2_ready),
    .stage_i (s1_stage),
    .kp_i    (kp_r),
    .ki_i    (ki_r),
    .kd_i    (kd_r),
    .valid_o (s2_valid),
    .ready_i (s3_ready),
    .stage_o (s2_stage)
  );

  phd_sum u_sum (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s2_valid),
    .ready_o (s3_ready),
    .stage_i (s2_stage),
    .valid_o (s3_valid),
    .ready_i (s4_ready),
    .stage_o (s3_stage)
  );

  phd_sat u_sat (
    .clk              (clk),
    .rst_n            (rst_n),
    .valid_i          (s3_valid),
    .ready_o          (s4_ready),
    .stage_i          (s3_stage),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_duty         (out_duty),
    .out_duty_written (out_duty_written)
  );

  // Requests in flight
  always_comb begin
    occ_nxt = occ_r;
    if (in_acc && !out_acc) begin
      occ_nxt = occ_r + 3'd1;
    end else if (out_acc && !in_acc) begin
      occ_nxt = occ_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // Input only backs up when every stage holds a request
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> occ_r == PIPE_DEPTH)
    else $error("input stalled with pipeline not full");

  // No result without a request in flight
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == 3'd0 |-> !out_valid)
    else $error("result shown with empty pipeline");

  // A result that is not issued carries duty 0
  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_duty_written |-> out_duty == '0)
    else $error("unissued result with nonzero duty");

endmodule
`default_nettype wire
